[hw/rtl/segment_intersection_tolerant_defines.svh]
// Assertion helpers used by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_TOLERANT_DEFINES_SVH
`define SEGMENT_INTERSECTION_TOLERANT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sit_pkg.sv]
package sit_pkg;

  // Coordinate order inside the packed coordinate bundle.
  localparam int NCRD = 8;
  localparam int IAX0 = 0;
  localparam int IAY0 = 1;
  localparam int IAX1 = 2;
  localparam int IAY1 = 3;
  localparam int IBX0 = 4;
  localparam int IBY0 = 5;
  localparam int IBX1 = 6;
  localparam int IBY1 = 7;

  // Slope format and the gain applied to a vertical segment's dy.
  localparam int SLOPE_INT_BITS = 16;
  localparam int VERT_GAIN      = 10;

  // Tolerance register.
  localparam int             TOL_W     = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd768;

  // Wide saturating domain: values are kept within +-2^62.
  localparam int LW            = 65;
  localparam int NMAG_W        = 63;
  localparam int WIDE_LIM_BIT  = 62;

  // Per-item decision flags carried alongside the point division.
  typedef struct packed {
    logic qneg;
    logic hva;
    logic hvb;
    logic eq;
    logic va;
    logic vb;
  } sit_flag_t;

endpackage

[hw/rtl/sit_div.sv]
module sit_div #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 33,
  parameter int Q_W   = 26,
  parameter int SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic             ovf_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int RW = DEN_W + Q_W;
  localparam int XW = (NUM_W > RW) ? NUM_W : RW;

  logic             vld_q [Q_W+1];
  logic [RW-1:0]    rem_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             ovf_q [Q_W+1];
  logic [SB_W-1:0]  sb_q  [Q_W+1];

  logic [XW-1:0] num_x;
  logic [XW-1:0] lim_x;

  // A quotient that does not fit in Q_W bits is flagged up front, so the
  // remainder afterwards always fits in RW bits.
  assign num_x = XW'(num_i);
  assign lim_x = XW'(den_i) << Q_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_x[RW-1:0];
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= (num_x >= lim_x);
    sb_q[0]  <= sb_i;
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int BIT = Q_W - 1 - k;
    logic [RW:0]    trial;
    logic           take;
    logic [RW-1:0]  rem_d;
    logic [Q_W-1:0] quo_d;

    always_comb begin
      trial = {1'b0, rem_q[k]} - {1'b0, (RW'(den_q[k]) << BIT)};
      take  = !trial[RW];
      rem_d = take ? trial[RW-1:0] : rem_q[k];
      quo_d = quo_q[k];
      quo_d[BIT] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_d;
      ovf_q[k+1] <= ovf_q[k];
      sb_q[k+1]  <= sb_q[k];
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quot_o  = quo_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign sb_o    = sb_q[Q_W];

endmodule

[hw/rtl/segment_intersection_tolerant.sv]
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// The bit-per-stage dividers (two slope dividers in parallel, then crossing x) set the pipeline depth.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets tolerance to 768 coordinate units.
module segment_intersection_tolerant
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH     = 24,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [TOL_W-1:0]              cfg_wdata_i,
  input  logic signed [COORD_WIDTH-1:0] ax0_i,
  input  logic signed [COORD_WIDTH-1:0] ay0_i,
  input  logic signed [COORD_WIDTH-1:0] ax1_i,
  input  logic signed [COORD_WIDTH-1:0] ay1_i,
  input  logic signed [COORD_WIDTH-1:0] bx0_i,
  input  logic signed [COORD_WIDTH-1:0] by0_i,
  input  logic signed [COORD_WIDTH-1:0] bx1_i,
  input  logic signed [COORD_WIDTH-1:0] by1_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          point_valid_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o
);

`include "segment_intersection_tolerant_defines.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int F     = SLOPE_FRAC_BITS;
  localparam int DW    = CW + 1;
  localparam int MW    = SLOPE_INT_BITS + F;
  localparam int SDW   = MW + 1;
  localparam int PW    = MW + DW;
  localparam int VW    = DW + F - 3;
  localparam int CLW   = (VW > MW) ? VW : MW;
  localparam int EW    = (PW > LW) ? PW : LW;
  localparam int Q2    = CW + 2;
  localparam int SW    = CW + TOL_W + 2;
  localparam int FW    = $bits(sit_flag_t);
  localparam int CRDW  = NCRD * CW;
  localparam int SB1_W = CRDW + 2;
  localparam int SB3_W = CRDW + MW + FW;
  localparam int LAT   = MW + Q2 + 10;

  localparam logic signed [VW-1:0]  VGAIN = VW'(VERT_GAIN) <<< (F - 8);
  localparam logic signed [CLW-1:0] SMAXC = (CLW'(1) <<< (MW - 1)) - CLW'(1);
  localparam logic signed [CLW-1:0] SMINC = -SMAXC - CLW'(1);
  localparam logic [MW-1:0]         HALF  = MW'(1) << (MW - 1);
  localparam logic signed [EW-1:0]  WHI_E = EW'(1) <<< WIDE_LIM_BIT;
  localparam logic signed [EW-1:0]  WLO_E = -WHI_E;
  localparam logic signed [LW-1:0]  WHI_L = LW'(1) <<< WIDE_LIM_BIT;
  localparam logic signed [LW-1:0]  WLO_L = -WHI_L;
  localparam logic signed [LW-1:0]  RND_L = (LW'(1) <<< F) - LW'(1);
  localparam logic signed [LW-1:0]  CMAX_L = (LW'(1) <<< (CW - 1)) - LW'(1);
  localparam logic signed [LW-1:0]  CMIN_L = -CMAX_L - LW'(1);
  localparam logic signed [Q2+1:0]  CMAX_Q = ((Q2+2)'(1) <<< (CW - 1)) - (Q2+2)'(1);
  localparam logic signed [Q2+1:0]  CMIN_Q = -CMAX_Q - (Q2+2)'(1);

  // Span check with tolerance on both sides.
  function automatic logic in_span(logic signed [SW-1:0] v, logic signed [SW-1:0] p,
                                   logic signed [SW-1:0] q, logic signed [SW-1:0] t);
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return (v >= lo - t) && (v <= hi + t);
  endfunction

  // Tolerance register.
  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Stage A: capture the input word.
  logic                     a_vld_q;
  logic [NCRD-1:0][CW-1:0]  a_crd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_crd_q[IAX0] <= ax0_i;
    a_crd_q[IAY0] <= ay0_i;
    a_crd_q[IAX1] <= ax1_i;
    a_crd_q[IAY1] <= ay1_i;
    a_crd_q[IBX0] <= bx0_i;
    a_crd_q[IBY0] <= by0_i;
    a_crd_q[IBX1] <= bx1_i;
    a_crd_q[IBY1] <= by1_i;
  end

  // Segment deltas and the unsigned operands for the slope dividers.
  logic signed [DW-1:0] a_dxa, a_dya, a_dxb, a_dyb;
  logic [DW-1:0]        a_adxa, a_adya, a_adxb, a_adyb;
  logic                 a_va, a_vb, a_nega, a_negb;

  always_comb begin
    a_dxa  = DW'($signed(a_crd_q[IAX1])) - DW'($signed(a_crd_q[IAX0]));
    a_dya  = DW'($signed(a_crd_q[IAY1])) - DW'($signed(a_crd_q[IAY0]));
    a_dxb  = DW'($signed(a_crd_q[IBX1])) - DW'($signed(a_crd_q[IBX0]));
    a_dyb  = DW'($signed(a_crd_q[IBY1])) - DW'($signed(a_crd_q[IBY0]));
    a_adxa = a_dxa[DW-1] ? DW'(-a_dxa) : DW'(a_dxa);
    a_adya = a_dya[DW-1] ? DW'(-a_dya) : DW'(a_dya);
    a_adxb = a_dxb[DW-1] ? DW'(-a_dxb) : DW'(a_dxb);
    a_adyb = a_dyb[DW-1] ? DW'(-a_dyb) : DW'(a_dyb);
    a_va   = (a_dxa == '0);
    a_vb   = (a_dxb == '0);
    a_nega = a_dxa[DW-1] ^ a_dya[DW-1];
    a_negb = a_dxb[DW-1] ^ a_dyb[DW-1];
  end

  logic             da_vld, db_vld, da_ovf, db_ovf;
  logic [MW-1:0]    da_q, db_q;
  logic [SB1_W-1:0] da_sb;
  logic [1:0]       db_sb;

  sit_div #(
    .NUM_W (DW + F),
    .DEN_W (DW),
    .Q_W   (MW),
    .SB_W  (SB1_W)
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_vld_q),
    .num_i   ({a_adya, {F{1'b0}}}),
    .den_i   (a_adxa),
    .sb_i    ({a_crd_q, a_va, a_nega}),
    .valid_o (da_vld),
    .quot_o  (da_q),
    .ovf_o   (da_ovf),
    .sb_o    (da_sb)
  );

  sit_div #(
    .NUM_W (DW + F),
    .DEN_W (DW),
    .Q_W   (MW),
    .SB_W  (2)
  ) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_vld_q),
    .num_i   ({a_adyb, {F{1'b0}}}),
    .den_i   (a_adxb),
    .sb_i    ({a_vb, a_negb}),
    .valid_o (db_vld),
    .quot_o  (db_q),
    .ovf_o   (db_ovf),
    .sb_o    (db_sb)
  );

  // Stage B: saturated slopes, vertical segments take dy times the gain.
  logic [NCRD-1:0][CW-1:0] s1_crd;
  logic signed [DW-1:0]    s1_dya, s1_dyb;
  logic signed [VW-1:0]    s1_vma, s1_vmb;
  logic signed [CLW-1:0]   s1_vxa, s1_vxb;
  logic signed [MW-1:0]    s1_vsa, s1_vsb;
  logic [MW-1:0]           s1_dsa, s1_dsb;
  logic signed [MW-1:0]    s1_ma, s1_mb;
  logic                    s1_va, s1_vb, s1_nega, s1_negb;

  always_comb begin
    s1_crd  = da_sb[SB1_W-1:2];
    s1_va   = da_sb[1];
    s1_nega = da_sb[0];
    s1_vb   = db_sb[1];
    s1_negb = db_sb[0];
    s1_dya  = DW'($signed(s1_crd[IAY1])) - DW'($signed(s1_crd[IAY0]));
    s1_dyb  = DW'($signed(s1_crd[IBY1])) - DW'($signed(s1_crd[IBY0]));
    s1_vma  = VW'(s1_dya) * VGAIN;
    s1_vmb  = VW'(s1_dyb) * VGAIN;
    s1_vxa  = CLW'(s1_vma);
    s1_vxb  = CLW'(s1_vmb);
    s1_vsa  = (s1_vxa > SMAXC) ? MW'(SMAXC) : ((s1_vxa < SMINC) ? MW'(SMINC) : MW'(s1_vxa));
    s1_vsb  = (s1_vxb > SMAXC) ? MW'(SMAXC) : ((s1_vxb < SMINC) ? MW'(SMINC) : MW'(s1_vxb));
    if (s1_nega) begin
      s1_dsa = (da_ovf || da_q > HALF) ? HALF : MW'(-da_q);
    end else begin
      s1_dsa = (da_ovf || da_q[MW-1]) ? HALF - MW'(1) : da_q;
    end
    if (s1_negb) begin
      s1_dsb = (db_ovf || db_q > HALF) ? HALF : MW'(-db_q);
    end else begin
      s1_dsb = (db_ovf || db_q[MW-1]) ? HALF - MW'(1) : db_q;
    end
    s1_ma = s1_va ? s1_vsa : $signed(s1_dsa);
    s1_mb = s1_vb ? s1_vsb : $signed(s1_dsb);
  end

  logic                    b_vld_q;
  logic [NCRD-1:0][CW-1:0] b_crd_q;
  logic signed [MW-1:0]    b_ma_q, b_mb_q;
  logic                    b_va_q, b_vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= da_vld && db_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    b_crd_q <= s1_crd;
    b_ma_q  <= s1_ma;
    b_mb_q  <= s1_mb;
    b_va_q  <= s1_va;
    b_vb_q  <= s1_vb;
  end

  // Stage C: slope times x offset between the segment starts.
  logic signed [DW-1:0] s2_dx0;
  logic signed [PW-1:0] s2_p1, s2_p2;

  always_comb begin
    s2_dx0 = DW'($signed(b_crd_q[IBX0])) - DW'($signed(b_crd_q[IAX0]));
    s2_p1  = PW'(b_mb_q) * PW'(s2_dx0);
    s2_p2  = PW'(b_ma_q) * PW'(s2_dx0);
  end

  logic                    c_vld_q;
  logic [NCRD-1:0][CW-1:0] c_crd_q;
  logic signed [PW-1:0]    c_p1_q, c_p2_q;
  logic signed [MW-1:0]    c_ma_q;
  logic signed [SDW-1:0]   c_d_q;
  logic                    c_eq_q, c_va_q, c_vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_crd_q <= b_crd_q;
    c_p1_q  <= s2_p1;
    c_p2_q  <= s2_p2;
    c_ma_q  <= b_ma_q;
    c_d_q   <= SDW'(b_ma_q) - SDW'(b_mb_q);
    c_eq_q  <= (b_ma_q == b_mb_q);
    c_va_q  <= b_va_q;
    c_vb_q  <= b_vb_q;
  end

  // Stage D: saturate products, form the numerator and the vertical tests.
  logic signed [EW-1:0] s3_p1e, s3_p2e;
  logic signed [LW-1:0] s3_p1c, s3_p2c, s3_nsum, s3_nc, s3_ta, s3_da, s3_db;
  logic [NMAG_W-1:0]    s3_nmag;
  logic [SDW-1:0]       s3_dmag;
  sit_flag_t            s3_flag;

  always_comb begin
    s3_p1e  = EW'(c_p1_q);
    s3_p2e  = EW'(c_p2_q);
    s3_p1c  = (s3_p1e > WHI_E) ? LW'(WHI_E) : ((s3_p1e < WLO_E) ? LW'(WLO_E) : LW'(s3_p1e));
    s3_p2c  = (s3_p2e > WHI_E) ? LW'(WHI_E) : ((s3_p2e < WLO_E) ? LW'(WLO_E) : LW'(s3_p2e));
    s3_nsum = (LW'(DW'($signed(c_crd_q[IBY0])) - DW'($signed(c_crd_q[IAY0]))) <<< F)
              - s3_p1c;
    s3_nc   = (s3_nsum > WHI_L) ? WHI_L : ((s3_nsum < WLO_L) ? WLO_L : s3_nsum);
    s3_nmag = s3_nc[LW-1] ? NMAG_W'(-s3_nc) : NMAG_W'(s3_nc);
    s3_dmag = c_d_q[SDW-1] ? SDW'(-c_d_q) : SDW'(c_d_q);
    // With A vertical the test value is B's product with the sign flipped.
    s3_ta   = -s3_p1c;
    s3_da   = LW'(DW'($signed(c_crd_q[IBY1])) - DW'($signed(c_crd_q[IBY0]))) <<< F;
    s3_db   = LW'(DW'($signed(c_crd_q[IAY1])) - DW'($signed(c_crd_q[IAY0]))) <<< F;
    s3_flag.qneg = s3_nc[LW-1] ^ c_d_q[SDW-1];
    s3_flag.hva  = (s3_ta > 0 && s3_ta < s3_da) || (s3_ta < 0 && s3_ta > s3_da);
    s3_flag.hvb  = (s3_p2c > 0 && s3_p2c < s3_db) || (s3_p2c < 0 && s3_p2c > s3_db);
    s3_flag.eq   = c_eq_q;
    s3_flag.va   = c_va_q;
    s3_flag.vb   = c_vb_q;
  end

  logic                    d_vld_q;
  logic [NCRD-1:0][CW-1:0] d_crd_q;
  logic [NMAG_W-1:0]       d_nmag_q;
  logic [SDW-1:0]          d_dmag_q;
  logic signed [MW-1:0]    d_ma_q;
  sit_flag_t               d_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_crd_q  <= c_crd_q;
    d_nmag_q <= s3_nmag;
    d_dmag_q <= s3_dmag;
    d_ma_q   <= c_ma_q;
    d_flag_q <= s3_flag;
  end

  logic             dp_vld, dp_ovf;
  logic [Q2-1:0]    dp_q;
  logic [SB3_W-1:0] dp_sb;

  sit_div #(
    .NUM_W (NMAG_W),
    .DEN_W (SDW),
    .Q_W   (Q2),
    .SB_W  (SB3_W)
  ) u_div_pt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_vld_q),
    .num_i   (d_nmag_q),
    .den_i   (d_dmag_q),
    .sb_i    ({d_crd_q, d_ma_q, d_flag_q}),
    .valid_o (dp_vld),
    .quot_o  (dp_q),
    .ovf_o   (dp_ovf),
    .sb_o    (dp_sb)
  );

  // Stage E: crossing x = ax0 + N / D, saturated.
  logic [NCRD-1:0][CW-1:0] s4_crd;
  logic signed [MW-1:0]    s4_ma;
  sit_flag_t               s4_flag;
  logic signed [Q2:0]      s4_qs;
  logic signed [Q2+1:0]    s4_sum;
  logic signed [CW-1:0]    s4_x;

  always_comb begin
    s4_crd  = dp_sb[SB3_W-1:MW+FW];
    s4_ma   = dp_sb[MW+FW-1:FW];
    s4_flag = dp_sb[FW-1:0];
    s4_qs   = s4_flag.qneg ? -$signed({1'b0, dp_q}) : $signed({1'b0, dp_q});
    s4_sum  = (Q2+2)'($signed(s4_crd[IAX0])) + (Q2+2)'(s4_qs);
    if (dp_ovf) begin
      s4_x = s4_flag.qneg ? CW'(CMIN_Q) : CW'(CMAX_Q);
    end else if (s4_sum > CMAX_Q) begin
      s4_x = CW'(CMAX_Q);
    end else if (s4_sum < CMIN_Q) begin
      s4_x = CW'(CMIN_Q);
    end else begin
      s4_x = CW'(s4_sum);
    end
  end

  logic                    e_vld_q;
  logic [NCRD-1:0][CW-1:0] e_crd_q;
  logic signed [MW-1:0]    e_ma_q;
  sit_flag_t               e_flag_q;
  logic signed [CW-1:0]    e_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= dp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    e_crd_q  <= s4_crd;
    e_ma_q   <= s4_ma;
    e_flag_q <= s4_flag;
    e_x_q    <= s4_x;
  end

  // Stage F: slope of A times the x offset from ax0.
  logic signed [DW-1:0] s5_dxx;
  logic signed [PW-1:0] s5_pr;

  always_comb begin
    s5_dxx = DW'(e_x_q) - DW'($signed(e_crd_q[IAX0]));
    s5_pr  = PW'(e_ma_q) * PW'(s5_dxx);
  end

  logic                    f_vld_q;
  logic [NCRD-1:0][CW-1:0] f_crd_q;
  sit_flag_t               f_flag_q;
  logic signed [CW-1:0]    f_x_q;
  logic signed [PW-1:0]    f_pr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_crd_q  <= e_crd_q;
    f_flag_q <= e_flag_q;
    f_x_q    <= e_x_q;
    f_pr_q   <= s5_pr;
  end

  // Stage G: crossing y = ay0 + product / 2^F, truncated toward zero.
  logic signed [EW-1:0] s6_pe;
  logic signed [LW-1:0] s6_pc, s6_yq, s6_ys;
  logic signed [CW-1:0] s6_y;

  always_comb begin
    s6_pe = EW'(f_pr_q);
    s6_pc = (s6_pe > WHI_E) ? LW'(WHI_E) : ((s6_pe < WLO_E) ? LW'(WLO_E) : LW'(s6_pe));
    s6_yq = (s6_pc + (s6_pc[LW-1] ? RND_L : LW'(0))) >>> F;
    s6_ys = s6_yq + LW'($signed(f_crd_q[IAY0]));
    s6_y  = (s6_ys > CMAX_L) ? CW'(CMAX_L) : ((s6_ys < CMIN_L) ? CW'(CMIN_L) : CW'(s6_ys));
  end

  logic                    g_vld_q;
  logic [NCRD-1:0][CW-1:0] g_crd_q;
  sit_flag_t               g_flag_q;
  logic signed [CW-1:0]    g_x_q, g_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_crd_q  <= f_crd_q;
    g_flag_q <= f_flag_q;
    g_x_q    <= f_x_q;
    g_y_q    <= s6_y;
  end

  // Stage H: span checks and result selection.
  logic signed [SW-1:0] s7_tol, s7_x, s7_y;
  logic                 s7_gen, s7_span, s7_hit;

  always_comb begin
    s7_tol  = $signed({{(SW - TOL_W){1'b0}}, tol_q});
    s7_x    = SW'(g_x_q);
    s7_y    = SW'(g_y_q);
    s7_span = in_span(s7_x, SW'($signed(g_crd_q[IAX0])), SW'($signed(g_crd_q[IAX1])), s7_tol)
           && in_span(s7_x, SW'($signed(g_crd_q[IBX0])), SW'($signed(g_crd_q[IBX1])), s7_tol)
           && in_span(s7_y, SW'($signed(g_crd_q[IAY0])), SW'($signed(g_crd_q[IAY1])), s7_tol)
           && in_span(s7_y, SW'($signed(g_crd_q[IBY0])), SW'($signed(g_crd_q[IBY1])), s7_tol);
    s7_gen  = !g_flag_q.eq && (g_flag_q.va == g_flag_q.vb);
    if (g_flag_q.eq) begin
      s7_hit = 1'b0;
    end else if (g_flag_q.va && !g_flag_q.vb) begin
      s7_hit = g_flag_q.hva;
    end else if (g_flag_q.vb && !g_flag_q.va) begin
      s7_hit = g_flag_q.hvb;
    end else begin
      s7_hit = s7_span;
    end
  end

  logic                 done_q, hit_q, pv_q;
  logic signed [CW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      pv_q   <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
    end else begin
      done_q <= g_vld_q;
      hit_q  <= g_vld_q && s7_hit;
      pv_q   <= g_vld_q && s7_gen;
      cx_q   <= (g_vld_q && s7_gen) ? g_x_q : '0;
      cy_q   <= (g_vld_q && s7_gen) ? g_y_q : '0;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign point_valid_o = pv_q;
  assign cross_x_o     = cx_q;
  assign cross_y_o     = cy_q;

  // Every result word traces back to an accepted word a fixed latency earlier.
  `SIT_ASSERT_IMP(a_done_traces_start, clk_i, rst_ni, done_o, $past(start && !busy, LAT), "result without matching accept")
  // Without a point the coordinates read as zero.
  `SIT_ASSERT_IMP(a_point_zero, clk_i, rst_ni, !point_valid_o, (cross_x_o == '0) && (cross_y_o == '0), "nonzero point when not valid")
  // A tolerance write takes effect on the next cycle.
  `SIT_ASSERT_NXT(a_tol_write, clk_i, rst_ni, cfg_we_i, tol_q == $past(cfg_wdata_i), "tolerance write lost")

endmodule
